/* design/coac_pkg.sv */
// Shared types and constants of the copy-or-append cost parser.
// Used by coac_mem, coac_ctrl and copy_or_append_cost_parser; depends on nothing.
package coac_pkg;

  localparam int MAX_LEN  = 4096;
  localparam int ALPHABET = 26;
  localparam int NODES    = 2 * MAX_LEN;

  localparam int SYM_W  = 5;
  localparam int POS_W  = $clog2(MAX_LEN + 1);
  localparam int NODE_W = $clog2(NODES);
  localparam int NC_W   = NODE_W + 1;
  localparam int TR_AW  = NODE_W + SYM_W;
  localparam int COST_W = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_APPEND_COST = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COPY_COST   = IDX_W'(1);

  localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(ALPHABET - 1);

  // Accesses issued by the sequencer to the stores in one cycle.
  typedef struct packed {
    logic [POS_W-1:0]  text_raddr;
    logic              text_we;
    logic [POS_W-1:0]  text_waddr;
    logic [SYM_W-1:0]  text_wdata;
    logic [NODE_W-1:0] len_raddr;
    logic              len_we;
    logic [NODE_W-1:0] len_waddr;
    logic [NODE_W-1:0] len_wdata;
    logic [NODE_W-1:0] link_raddr;
    logic              link_we;
    logic [NODE_W-1:0] link_waddr;
    logic [NODE_W-1:0] link_wdata;
    logic [TR_AW-1:0]  tr_raddr;
    logic              tr_we;
    logic [TR_AW-1:0]  tr_waddr;
    logic [NODE_W-1:0] tr_wdata;
    logic [POS_W-1:0]  cost_raddr;
    logic              cost_we;
    logic [POS_W-1:0]  cost_waddr;
    logic [COST_W-1:0] cost_wdata;
  } mem_req_t;

  // Registered read data, valid in the cycle after the address.
  typedef struct packed {
    logic [SYM_W-1:0]  text_q;
    logic [NODE_W-1:0] len_q;
    logic [NODE_W-1:0] link_q;
    logic [NODE_W-1:0] tr_q;
    logic [COST_W-1:0] cost_q;
  } mem_rsp_t;

endpackage

/* design/coac_mem.sv */
// Storage of the parser: text, node lengths, suffix links, transitions and costs.
// Depends on coac_pkg for widths and the request and response structs.
module coac_mem (
  input  logic              clk,
  input  coac_pkg::mem_req_t req,
  output coac_pkg::mem_rsp_t rsp
);

  logic [coac_pkg::SYM_W-1:0]  text_mem [coac_pkg::MAX_LEN+1];
  logic [coac_pkg::NODE_W-1:0] len_mem  [coac_pkg::NODES];
  logic [coac_pkg::NODE_W-1:0] link_mem [coac_pkg::NODES];
  logic [coac_pkg::NODE_W-1:0] tr_mem   [2**coac_pkg::TR_AW];
  logic [coac_pkg::COST_W-1:0] cost_mem [coac_pkg::MAX_LEN+1];

  // Each store has one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.text_we) begin
      text_mem[req.text_waddr] <= req.text_wdata;
    end
    if (req.len_we) begin
      len_mem[req.len_waddr] <= req.len_wdata;
    end
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    if (req.tr_we) begin
      tr_mem[req.tr_waddr] <= req.tr_wdata;
    end
    if (req.cost_we) begin
      cost_mem[req.cost_waddr] <= req.cost_wdata;
    end
    rsp.text_q <= text_mem[req.text_raddr];
    rsp.len_q  <= len_mem[req.len_raddr];
    rsp.link_q <= link_mem[req.link_raddr];
    rsp.tr_q   <= tr_mem[req.tr_raddr];
    rsp.cost_q <= cost_mem[req.cost_raddr];
  end

endmodule

/* design/coac_ctrl.sv */
// Sequencer that matches symbols, extends the suffix automaton and computes costs.
// Depends on coac_pkg; drives the stores in coac_mem one access per port per cycle.
module coac_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [coac_pkg::CFG_W-1:0]  append_cost,
  input  logic [coac_pkg::CFG_W-1:0]  copy_cost,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [coac_pkg::SYM_W-1:0]  in_symbol,
  input  logic                        in_end_of_string,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [coac_pkg::COST_W-1:0] out_total_cost,
  output logic                        out_overflow,
  output coac_pkg::mem_req_t          req,
  input  coac_pkg::mem_rsp_t          rsp
);

  typedef enum logic [25:0] {
    S_CLRR = 26'h0000001, S_IDLE = 26'h0000002, S_CHK  = 26'h0000004,
    S_CHKW = 26'h0000008, S_GSYM = 26'h0000010, S_G1   = 26'h0000020,
    S_CLRL = 26'h0000040, S_G2   = 26'h0000080, S_G3   = 26'h0000100,
    S_G4   = 26'h0000200, S_H1   = 26'h0000400, S_H2   = 26'h0000800,
    S_CPR  = 26'h0001000, S_CPW  = 26'h0002000, S_H3   = 26'h0004000,
    S_H4   = 26'h0008000, S_H5   = 26'h0010000, S_R1   = 26'h0020000,
    S_R2   = 26'h0040000, S_GEND = 26'h0080000, S_W0   = 26'h0100000,
    S_W1   = 26'h0200000, S_W2   = 26'h0400000, S_F1   = 26'h0800000,
    S_F2   = 26'h1000000, S_OUT  = 26'h2000000
  } state_t;

  localparam int NW = coac_pkg::NODE_W;
  localparam int PW = coac_pkg::POS_W;
  localparam int SW = coac_pkg::SYM_W;
  localparam int CW = coac_pkg::COST_W;

  state_t state_r, state_nxt;
  logic [coac_pkg::NC_W-1:0] nc_r, nc_nxt;
  logic [NW-1:0] last_r, last_nxt, mn_r, mn_nxt, kk_r, kk_nxt;
  logic [NW-1:0] leaf_r, leaf_nxt, t_r, t_nxt, cl_r, cl_nxt, f_r, f_nxt, lk_r, lk_nxt;
  logic [PW-1:0] pos_r, pos_nxt, cs_r, cs_nxt, i_r, i_nxt;
  logic [SW-1:0] c_r, c_nxt, gc_r, gc_nxt, cnt_r, cnt_nxt;
  logic          eos_r, eos_nxt, ovf_r, ovf_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW:0]   best_r, best_nxt;

  logic [NW-1:0] alloc_id;
  logic [coac_pkg::NC_W-1:0] alloc_nc;
  logic [SW-1:0] sym_sat;
  logic          j_le_i;
  logic [CW:0]   alt;
  logic [CW:0]   pick;

  // Node allocation saturates at the last node id.
  always_comb begin
    if (nc_r >= coac_pkg::NC_W'(coac_pkg::NODES)) begin
      alloc_id = NW'(coac_pkg::NODES - 1);
      alloc_nc = nc_r;
    end else begin
      alloc_id = nc_r[NW-1:0];
      alloc_nc = nc_r + 1'b1;
    end
  end

  assign sym_sat = (in_symbol > coac_pkg::LAST_SYM) ? coac_pkg::LAST_SYM : in_symbol;
  assign j_le_i  = (cs_r <= i_r);
  assign alt     = {1'b0, rsp.cost_q} + (CW+1)'(copy_cost);
  assign pick    = (j_le_i && (alt < best_r)) ? alt : best_r;

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_total_cost = cur_r;
  assign out_overflow   = ovf_r;

  // Next state, working registers and store accesses.
  always_comb begin
    state_nxt = state_r;
    nc_nxt = nc_r;   last_nxt = last_r; mn_nxt = mn_r;   kk_nxt = kk_r;
    leaf_nxt = leaf_r; t_nxt = t_r;   cl_nxt = cl_r;     f_nxt = f_r;
    lk_nxt = lk_r;   pos_nxt = pos_r;   cs_nxt = cs_r;   i_nxt = i_r;
    c_nxt = c_r;     gc_nxt = gc_r;     cnt_nxt = cnt_r; eos_nxt = eos_r;
    ovf_nxt = ovf_r; cur_nxt = cur_r;   best_nxt = best_r;
    req = '0;

    case (state_r)
      // Clear the root's transitions, its length and the zero-length cost.
      S_CLRR: begin
        req.tr_we    = 1'b1;
        req.tr_waddr = {NW'(0), cnt_r};
        req.len_we    = 1'b1;
        req.len_waddr = '0;
        req.cost_we  = 1'b1;
        req.cost_waddr = '0;
        if (cnt_r == coac_pkg::LAST_SYM) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          c_nxt   = sym_sat;
          eos_nxt = in_end_of_string;
          if (pos_r >= PW'(coac_pkg::MAX_LEN)) begin
            ovf_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            ovf_nxt = 1'b0;
            i_nxt   = pos_r + 1'b1;
            req.text_we    = 1'b1;
            req.text_waddr = pos_r + 1'b1;
            req.text_wdata = sym_sat;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        req.tr_raddr = {mn_r, c_r};
        state_nxt = S_CHKW;
      end
      S_CHKW: begin
        if (rsp.tr_q == '0 && j_le_i) begin
          req.text_raddr = cs_r;
          state_nxt = S_GSYM;
        end else begin
          if (j_le_i) begin
            mn_nxt = rsp.tr_q;
          end
          req.cost_raddr = i_r - 1'b1;
          state_nxt = S_F1;
        end
      end
      // Start of one automaton extension with the next prefix symbol.
      S_GSYM: begin
        gc_nxt = rsp.text_q;
        kk_nxt = last_r;
        req.len_raddr = last_r;
        state_nxt = S_G1;
      end
      S_G1: begin
        leaf_nxt = alloc_id;
        nc_nxt   = alloc_nc;
        req.len_we    = 1'b1;
        req.len_waddr = alloc_id;
        req.len_wdata = rsp.len_q + 1'b1;
        req.link_we    = 1'b1;
        req.link_waddr = alloc_id;
        cnt_nxt   = '0;
        state_nxt = S_CLRL;
      end
      S_CLRL: begin
        req.tr_we    = 1'b1;
        req.tr_waddr = {leaf_r, cnt_r};
        if (cnt_r == coac_pkg::LAST_SYM) begin
          req.tr_raddr = {kk_r, gc_r};
          state_nxt = S_G3;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_G2: begin
        req.tr_raddr = {kk_r, gc_r};
        state_nxt = S_G3;
      end
      // Walk suffix links, adding edges to the new leaf until one exists.
      S_G3: begin
        if (rsp.tr_q != '0) begin
          t_nxt = rsp.tr_q;
          req.len_raddr = kk_r;
          state_nxt = S_H1;
        end else begin
          req.tr_we    = 1'b1;
          req.tr_waddr = {kk_r, gc_r};
          req.tr_wdata = leaf_r;
          if (kk_r == '0) begin
            state_nxt = S_GEND;
          end else begin
            req.link_raddr = kk_r;
            state_nxt = S_G4;
          end
        end
      end
      S_G4: begin
        kk_nxt = rsp.link_q;
        req.tr_raddr = {rsp.link_q, gc_r};
        state_nxt = S_G3;
      end
      S_H1: begin
        lk_nxt = rsp.len_q;
        req.len_raddr = t_r;
        state_nxt = S_H2;
      end
      // Solid edge links the leaf directly; otherwise the target is split.
      S_H2: begin
        if (rsp.len_q == lk_r + 1'b1) begin
          req.link_we    = 1'b1;
          req.link_waddr = leaf_r;
          req.link_wdata = t_r;
          state_nxt = S_GEND;
        end else begin
          cl_nxt = alloc_id;
          nc_nxt = alloc_nc;
          req.len_we    = 1'b1;
          req.len_waddr = alloc_id;
          req.len_wdata = lk_r + 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_CPR;
        end
      end
      S_CPR: begin
        req.tr_raddr = {t_r, cnt_r};
        state_nxt = S_CPW;
      end
      S_CPW: begin
        req.tr_we    = 1'b1;
        req.tr_waddr = {cl_r, cnt_r};
        req.tr_wdata = rsp.tr_q;
        if (cnt_r == coac_pkg::LAST_SYM) begin
          req.link_raddr = t_r;
          state_nxt = S_H3;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_CPR;
        end
      end
      S_H3: begin
        req.link_we    = 1'b1;
        req.link_waddr = cl_r;
        req.link_wdata = rsp.link_q;
        state_nxt = S_H4;
      end
      S_H4: begin
        req.link_we    = 1'b1;
        req.link_waddr = t_r;
        req.link_wdata = cl_r;
        state_nxt = S_H5;
      end
      S_H5: begin
        req.link_we    = 1'b1;
        req.link_waddr = leaf_r;
        req.link_wdata = cl_r;
        req.tr_raddr   = {kk_r, gc_r};
        state_nxt = S_R1;
      end
      // Redirect edges that pointed to the split node onto the clone.
      S_R1: begin
        if (rsp.tr_q != t_r) begin
          state_nxt = S_GEND;
        end else begin
          req.tr_we    = 1'b1;
          req.tr_waddr = {kk_r, gc_r};
          req.tr_wdata = cl_r;
          if (kk_r == '0) begin
            state_nxt = S_GEND;
          end else begin
            req.link_raddr = kk_r;
            state_nxt = S_R2;
          end
        end
      end
      S_R2: begin
        kk_nxt = rsp.link_q;
        req.tr_raddr = {rsp.link_q, gc_r};
        state_nxt = S_R1;
      end
      S_GEND: begin
        last_nxt  = leaf_r;
        cs_nxt    = cs_r + 1'b1;
        state_nxt = S_W0;
      end
      // Shorten the match while the parent still covers the remaining length.
      S_W0: begin
        if (mn_r == '0) begin
          state_nxt = S_CHK;
        end else begin
          req.link_raddr = mn_r;
          state_nxt = S_W1;
        end
      end
      S_W1: begin
        f_nxt = rsp.link_q;
        if (!j_le_i) begin
          mn_nxt    = rsp.link_q;
          state_nxt = S_W0;
        end else begin
          req.len_raddr = rsp.link_q;
          state_nxt = S_W2;
        end
      end
      S_W2: begin
        if (PW'(rsp.len_q) >= i_r - cs_r) begin
          mn_nxt    = f_r;
          state_nxt = S_W0;
        end else begin
          state_nxt = S_CHK;
        end
      end
      // Cost of appending, then of copying, saturated to 32 bits.
      S_F1: begin
        best_nxt = {1'b0, rsp.cost_q} + (CW+1)'(append_cost);
        req.cost_raddr = cs_r - 1'b1;
        state_nxt = S_F2;
      end
      S_F2: begin
        cur_nxt = pick[CW] ? {CW{1'b1}} : pick[CW-1:0];
        req.cost_we    = 1'b1;
        req.cost_waddr = i_r;
        req.cost_wdata = pick[CW] ? {CW{1'b1}} : pick[CW-1:0];
        pos_nxt   = i_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (eos_r) begin
            nc_nxt   = coac_pkg::NC_W'(1);
            last_nxt = '0;
            cs_nxt   = PW'(1);
            mn_nxt   = '0;
            pos_nxt  = '0;
            cur_nxt  = '0;
            cnt_nxt  = '0;
            state_nxt = S_CLRR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLRR;
      nc_r    <= coac_pkg::NC_W'(1);
      last_r  <= '0;
      mn_r    <= '0;
      cs_r    <= PW'(1);
      pos_r   <= '0;
      cur_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nc_r    <= nc_nxt;
      last_r  <= last_nxt;
      mn_r    <= mn_nxt;
      cs_r    <= cs_nxt;
      pos_r   <= pos_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Working registers of one transaction.
  always_ff @(posedge clk) begin
    kk_r   <= kk_nxt;
    leaf_r <= leaf_nxt;
    t_r    <= t_nxt;
    cl_r   <= cl_nxt;
    f_r    <= f_nxt;
    lk_r   <= lk_nxt;
    i_r    <= i_nxt;
    c_r    <= c_nxt;
    gc_r   <= gc_nxt;
    eos_r  <= eos_nxt;
    best_r <= best_nxt;
  end

endmodule

/* design/copy_or_append_cost_parser.sv */
// Top level of the copy-or-append cost parser: configuration registers and hookup.
// Depends on coac_pkg, coac_mem and coac_ctrl.
//
// One symbol is taken per transaction and one result follows it: the least cost of
// building the text so far by appending single letters or copying substrings of the
// prefix. Each extension of the automaton clears the new node's transition row,
// then walks suffix links adding or redirecting edges, and copies the row of a
// node into a clone when that node is split; the match is then shortened along
// suffix links. These steps are paced by the single read port of the transition
// store. The amortized cost is linear in the string length. After reset and after
// each end_of_string result, the root row is cleared, during which no symbol is
// taken.
// Configuration is written at any time the port is ready.
module copy_or_append_cost_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [coac_pkg::SYM_W-1:0]  in_symbol,
  input  logic                        in_end_of_string,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [coac_pkg::COST_W-1:0] out_total_cost,
  output logic                        out_overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [coac_pkg::IDX_W-1:0]  cfg_index,
  input  logic [coac_pkg::CFG_W-1:0]  cfg_data
);

  logic [coac_pkg::CFG_W-1:0] append_cost_r, copy_cost_r;
  coac_pkg::mem_req_t req;
  coac_pkg::mem_rsp_t rsp;

  assign cfg_ready = 1'b1;

  // Cost registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      append_cost_r <= coac_pkg::CFG_W'(1);
      copy_cost_r   <= coac_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == coac_pkg::REG_APPEND_COST) begin
        append_cost_r <= cfg_data;
      end
      if (cfg_index == coac_pkg::REG_COPY_COST) begin
        copy_cost_r <= cfg_data;
      end
    end
  end

  coac_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .append_cost      (append_cost_r),
    .copy_cost        (copy_cost_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_symbol        (in_symbol),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total_cost   (out_total_cost),
    .out_overflow     (out_overflow),
    .req              (req),
    .rsp              (rsp)
  );

  coac_mem u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

endmodule
